// ===== hw/rtl/dtp_pkg.sv =====
package dtp_pkg;

	// pixel coordinate bits actually used
	localparam int COORD_BITS = 12;

	localparam int PIX_W  = 12;             // column / row / disparity field width
	localparam int CFG_W  = 32;             // config data width
	localparam int XW     = 34;             // signed offset from principal point
	localparam int MW     = XW - 1;         // magnitude of that offset
	localparam int DW     = 44;             // divisor magnitude
	localparam int NW     = 64;             // dividend magnitude
	localparam int QB     = 33;             // quotient bits produced
	localparam int HW     = NW - QB;        // dividend bits seeding the remainder

	typedef enum logic [2:0] {
		CFG_MODE  = 3'd0,
		CFG_FOCAL = 3'd1,
		CFG_CX    = 3'd2,
		CFG_CY    = 3'd3,
		CFG_BASE  = 3'd4,
		CFG_INVB  = 3'd5,
		CFG_WOFF  = 3'd6
	} cfg_idx_t;

	// one coordinate in flight through the divider
	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QB-1:0] nq;   // dividend bits still to shift into the remainder, quotient bits shifting in
		logic          ovf;
		logic          nz;
		logic          neg;
	} lane_t;

	// per-item flags that ride along the pipe
	typedef struct packed {
		logic pvalid;
		logic wzero;
	} tag_t;

endpackage

// ===== hw/rtl/dtp_ifs.sv =====
interface dtp_pix_if;
	logic                             valid;
	logic                             ready;
	logic        [dtp_pkg::PIX_W-1:0] column;
	logic        [dtp_pkg::PIX_W-1:0] row;
	logic signed [dtp_pkg::PIX_W-1:0] disparity;

	modport source(output valid, column, row, disparity, input ready);
	modport sink(input valid, column, row, disparity, output ready);
endinterface

interface dtp_pnt_if;
	logic        valid;
	logic        ready;
	logic [31:0] point_x;
	logic [31:0] point_y;
	logic [31:0] point_z;
	logic        point_valid;
	logic        range_error;

	modport source(output valid, point_x, point_y, point_z, point_valid, range_error,
		input ready);
	modport sink(input valid, point_x, point_y, point_z, point_valid, range_error,
		output ready);
endinterface

// ===== hw/rtl/disparity_to_3d_point_core.sv =====
// Channel | Dir | Handshake      | Request carries
// pix     | in  | valid / ready  | column, row, disparity
// pnt     | out | valid / ready  | point_x, point_y, point_z, point_valid, range_error
// cfg     | in  | cfg_we only    | cfg_index, cfg_data (no back-pressure)
//
// One request enters per clock while the pipe is not stalled. The pipe holds three
// prep stages, a range check stage, one stage per quotient bit of the 33-step
// restoring divider, and the output register; the divider chain is most of it.
// Every stage has its own valid bit and moves when empty or when the stage
// after it moves, so bubbles close up and a stall drops or repeats nothing.
// arst_n clears the valid bits and the config registers only.

module disparity_to_3d_point_core (
	input  logic              clk,
	input  logic              arst_n,
	dtp_pix_if.sink           pix,
	dtp_pnt_if.source         pnt,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	localparam int DW = dtp_pkg::DW;
	localparam int NW = dtp_pkg::NW;
	localparam int QB = dtp_pkg::QB;
	localparam int XW = dtp_pkg::XW;
	localparam int MW = dtp_pkg::MW;
	localparam int HW = dtp_pkg::HW;
	localparam int CB = dtp_pkg::COORD_BITS;

	// ------------------------------------------------------------------
	// Config registers. Baseline magnitude and sign are kept pre-split so
	// the projection multiply sees a plain unsigned operand.
	// ------------------------------------------------------------------
	logic               mode_q;
	logic [30:0]        focal_q;
	logic [31:0]        cx_q;
	logic [31:0]        cy_q;
	logic [31:0]        bmag_q;
	logic               bneg_q;
	logic signed [31:0] invb_q;
	logic [31:0]        woff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			focal_q <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			bmag_q  <= '0;
			bneg_q  <= 1'b0;
			invb_q  <= '0;
			woff_q  <= '0;
		end else if (cfg_we) begin
			case (dtp_pkg::cfg_idx_t'(cfg_index))
				dtp_pkg::CFG_MODE:  mode_q  <= cfg_data[0];
				dtp_pkg::CFG_FOCAL: focal_q <= cfg_data[30:0];
				dtp_pkg::CFG_CX:    cx_q    <= cfg_data;
				dtp_pkg::CFG_CY:    cy_q    <= cfg_data;
				dtp_pkg::CFG_BASE: begin
					bneg_q <= cfg_data[31];
					bmag_q <= cfg_data[31] ? (~cfg_data + 32'd1) : cfg_data;
				end
				dtp_pkg::CFG_INVB:  invb_q  <= cfg_data;
				dtp_pkg::CFG_WOFF:  woff_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage valids and advance enables (back to front)
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic dv_s [QB];
	logic out_v_q;
	logic en_s1, en_s2, en_s3, en_s4, en_out;
	logic en_d [QB];

	assign en_out = !out_v_q || pnt.ready;

	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_en
			if (k == QB - 1) begin : g_last
				assign en_d[k] = !dv_s[k] || en_out;
			end else begin : g_mid
				assign en_d[k] = !dv_s[k] || en_d[k+1];
			end
		end
	endgenerate

	assign en_s4 = !v_s4 || en_d[0];
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign pix.ready = en_s1;

	// ------------------------------------------------------------------
	// S1: offsets from the principal point, disparity times matrix factor
	// ------------------------------------------------------------------
	logic signed [XW-1:0] nx_s1, ny_s1;
	logic signed [DW-1:0] dprod_s1;
	logic        [11:0]   d_s1;
	logic                 pv_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && pix.valid) begin
			nx_s1 <= $signed({{(XW-CB-16){1'b0}}, pix.column[CB-1:0], 16'h0})
				- $signed({{(XW-32){cx_q[31]}}, cx_q});
			ny_s1 <= $signed({{(XW-CB-16){1'b0}}, pix.row[CB-1:0], 16'h0})
				- $signed({{(XW-32){cy_q[31]}}, cy_q});
			dprod_s1 <= pix.disparity * invb_q;
			d_s1     <= pix.disparity;
			pv_s1    <= pix.disparity > 12'sd1;
		end
	end

	// ------------------------------------------------------------------
	// S2: magnitudes and signs, w = d*inv + offset
	// ------------------------------------------------------------------
	logic [XW-1:0]        nx_abs, ny_abs;
	logic [MW-1:0]        nxm_s2, nym_s2;
	logic                 nxn_s2, nyn_s2;
	logic signed [DW-1:0] w_s2;
	logic        [11:0]   d_s2;
	logic                 pv_s2;

	assign nx_abs = nx_s1[XW-1] ? -nx_s1 : nx_s1;
	assign ny_abs = ny_s1[XW-1] ? -ny_s1 : ny_s1;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			nxm_s2 <= nx_abs[MW-1:0];
			nym_s2 <= ny_abs[MW-1:0];
			nxn_s2 <= nx_s1[XW-1];
			nyn_s2 <= ny_s1[XW-1];
			w_s2   <= dprod_s1 + $signed({{(DW-32){woff_q[31]}}, woff_q});
			d_s2   <= d_s1;
			pv_s2  <= pv_s1;
		end
	end

	// ------------------------------------------------------------------
	// S3: dividends and divisor for the selected mode
	// ------------------------------------------------------------------
	logic [MW+31:0] px_prod, py_prod;
	logic [62:0]    pz_prod;
	logic [DW-1:0]  w_abs;
	logic           wn;
	logic [NW-1:0]  num_s3 [3];
	logic           neg_s3 [3];
	logic [DW-1:0]  den_s3;
	dtp_pkg::tag_t  tag_s3;

	assign px_prod = nxm_s2 * bmag_q;
	assign py_prod = nym_s2 * bmag_q;
	assign pz_prod = focal_q * bmag_q;
	assign wn      = w_s2[DW-1];
	assign w_abs   = wn ? -w_s2 : w_s2;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			tag_s3.pvalid <= pv_s2;
			if (mode_q) begin
				num_s3[0] <= {{(NW-MW-16){1'b0}}, nxm_s2, 16'h0};
				num_s3[1] <= {{(NW-MW-16){1'b0}}, nym_s2, 16'h0};
				num_s3[2] <= {{(NW-47){1'b0}}, focal_q, 16'h0};
				neg_s3[0] <= nxn_s2 ^ wn;
				neg_s3[1] <= nyn_s2 ^ wn;
				neg_s3[2] <= wn;
				den_s3    <= w_abs;
				tag_s3.wzero <= (w_s2 == '0);
			end else begin
				num_s3[0] <= px_prod[NW-1:0];
				num_s3[1] <= py_prod[NW-1:0];
				num_s3[2] <= {{(NW-63){1'b0}}, pz_prod};
				neg_s3[0] <= nxn_s2 ^ bneg_q;
				neg_s3[1] <= nyn_s2 ^ bneg_q;
				neg_s3[2] <= bneg_q;
				den_s3    <= {{(DW-28){1'b0}}, d_s2, 16'h0};
				tag_s3.wzero <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// S4: range check - quotient fits in QB bits only if num[hi] < den
	// ------------------------------------------------------------------
	dtp_pkg::lane_t ln_s4 [3];
	logic [DW-1:0]  den_s4;
	dtp_pkg::tag_t  tag_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			for (int i = 0; i < 3; i++) begin
				ln_s4[i].rem <= {{(DW-HW){1'b0}}, num_s3[i][NW-1:QB]};
				ln_s4[i].nq  <= num_s3[i][QB-1:0];
				ln_s4[i].ovf <= {{(DW-HW){1'b0}}, num_s3[i][NW-1:QB]} >= den_s3;
				ln_s4[i].nz  <= num_s3[i] != '0;
				ln_s4[i].neg <= neg_s3[i];
			end
			den_s4 <= den_s3;
			tag_s4 <= tag_s3;
		end
	end

	// ------------------------------------------------------------------
	// Restoring divider: one quotient bit per stage, three lanes abreast
	// ------------------------------------------------------------------
	function automatic dtp_pkg::lane_t div_step(dtp_pkg::lane_t l, logic [DW-1:0] den);
		dtp_pkg::lane_t o;
		logic [DW:0]    r2;
		logic [DW:0]    diff;
		logic           ge;
		o    = l;
		r2   = {l.rem, l.nq[QB-1]};
		diff = r2 - {1'b0, den};
		ge   = r2 >= {1'b0, den};
		o.rem = ge ? diff[DW-1:0] : r2[DW-1:0];
		o.nq  = {l.nq[QB-2:0], ge};
		return o;
	endfunction

	dtp_pkg::lane_t ln_d_s  [QB][3];
	logic [DW-1:0]  den_d_s [QB];
	dtp_pkg::tag_t  tag_d_s [QB];

	generate
		for (k = 0; k < QB; k++) begin : g_div
			dtp_pkg::lane_t in_ln [3];
			logic [DW-1:0]  in_den;
			dtp_pkg::tag_t  in_tag;
			logic           in_v;
			if (k == 0) begin : g_first
				assign in_ln  = ln_s4;
				assign in_den = den_s4;
				assign in_tag = tag_s4;
				assign in_v   = v_s4;
			end else begin : g_next
				assign in_ln  = ln_d_s[k-1];
				assign in_den = den_d_s[k-1];
				assign in_tag = tag_d_s[k-1];
				assign in_v   = dv_s[k-1];
			end

			always_ff @(posedge clk) begin
				if (en_d[k] && in_v) begin
					for (int i = 0; i < 3; i++) begin
						ln_d_s[k][i] <= div_step(in_ln[i], in_den);
					end
					den_d_s[k] <= in_den;
					tag_d_s[k] <= in_tag;
				end
			end
		end
	endgenerate

	// ------------------------------------------------------------------
	// Output: sign, saturation, error flag
	// ------------------------------------------------------------------
	// returns {err, value}
	function automatic logic [32:0] sat_q(dtp_pkg::lane_t l);
		logic [QB-1:0] q;
		q = l.nq;
		if (!l.nz) begin
			return 33'h0;
		end else if (l.ovf) begin
			return {1'b1, l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
		end else if (l.neg) begin
			if (q > 33'h0_8000_0000) return {1'b1, 32'h8000_0000};
			else return {1'b0, -q[31:0]};
		end else begin
			if (q > 33'h0_7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
			else return {1'b0, q[31:0]};
		end
	endfunction

	logic [32:0] sx, sy, sz;
	logic [31:0] ox_q, oy_q, oz_q;
	logic        opv_q, oerr_q;

	assign sx = sat_q(ln_d_s[QB-1][0]);
	assign sy = sat_q(ln_d_s[QB-1][1]);
	assign sz = sat_q(ln_d_s[QB-1][2]);

	always_ff @(posedge clk) begin
		if (en_out && dv_s[QB-1]) begin
			if (tag_d_s[QB-1].pvalid) begin
				ox_q   <= sx[31:0];
				oy_q   <= sy[31:0];
				oz_q   <= sz[31:0];
				opv_q  <= 1'b1;
				oerr_q <= tag_d_s[QB-1].wzero || sx[32] || sy[32] || sz[32];
			end else begin
				ox_q   <= '0;
				oy_q   <= '0;
				oz_q   <= '0;
				opv_q  <= 1'b0;
				oerr_q <= 1'b0;
			end
		end
	end

	assign pnt.valid       = out_v_q;
	assign pnt.point_x     = ox_q;
	assign pnt.point_y     = oy_q;
	assign pnt.point_z     = oz_q;
	assign pnt.point_valid = opv_q;
	assign pnt.range_error = oerr_q;

	// ------------------------------------------------------------------
	// Valid bits
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < QB; i++) dv_s[i] <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_d[0]) dv_s[0] <= v_s4;
			for (int i = 1; i < QB; i++) begin
				if (en_d[i]) dv_s[i] <= dv_s[i-1];
			end
			if (en_out) out_v_q <= dv_s[QB-1];
		end
	end

endmodule

// ===== hw/rtl/dtp_checker.sv =====
module dtp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] point_x,
	input logic [31:0] point_y,
	input logic [31:0] point_z,
	input logic        point_valid,
	input logic        range_error
);

	// held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
			&& $stable(point_z) && $stable(point_valid) && $stable(range_error))
		else $error("result changed while stalled");

	// an empty output means the whole pipe can move, so the input is ready
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// invalid point is all zero and carries no error
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> point_x == 32'h0 && point_y == 32'h0
			&& point_z == 32'h0 && !range_error)
		else $error("invalid point not cleared");

	// handshake lines are always driven to a known level
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_ready, out_valid, out_ready}))
		else $error("handshake line unknown");

endmodule

bind disparity_to_3d_point_core dtp_checker u_dtp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pix.valid),
	.in_ready    (pix.ready),
	.out_valid   (pnt.valid),
	.out_ready   (pnt.ready),
	.point_x     (pnt.point_x),
	.point_y     (pnt.point_y),
	.point_z     (pnt.point_z),
	.point_valid (pnt.point_valid),
	.range_error (pnt.range_error)
);
